// ----- rtl/h2sp_pkg.sv -----
// Shared types, constants and helpers for the HTTP/2 SETTINGS payload parser.
`timescale 1ns / 1ps

package h2sp_pkg;

	localparam int EntryBytes = 6;
	localparam logic [31:0] MaxWindow = 32'h7FFF_FFFF;
	localparam logic [31:0] MinFrame = 32'd16384;
	localparam logic [31:0] MaxFrame = 32'd16777215;

	localparam logic [31:0] ResetMaxStreams = 32'hFFFF_FFFF;
	localparam logic [30:0] ResetInitWindow = 31'd65535;
	localparam logic [23:0] ResetMaxFrame = 24'd16384;
	localparam logic [31:0] ResetMaxHdrList = 32'hFFFF_FFFF;

	// setting identifiers
	localparam logic [15:0] IdMaxStreams = 16'd3;
	localparam logic [15:0] IdInitWindow = 16'd4;
	localparam logic [15:0] IdMaxFrame = 16'd5;
	localparam logic [15:0] IdMaxHdrList = 16'd6;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_LEN    = 2'd1,
		ST_BAD_WINDOW = 2'd2,
		ST_BAD_FRAME  = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] max_streams;
		logic [30:0] initial_window;
		logic [23:0] max_frame;
		logic [31:0] max_header_list;
	} peer_t;

	// length % 6 == 0: even, and base-4 digit sum divisible by three
	function automatic logic len_mult6(input logic [23:0] len);
		logic [5:0] sum1;
		logic [3:0] sum2;
		sum1 = '0;
		for (int i = 0; i < 12; i++) begin
			sum1 = sum1 + {4'd0, len[2*i +: 2]};
		end
		sum2 = {2'd0, sum1[1:0]} + {2'd0, sum1[3:2]} + {2'd0, sum1[5:4]};
		return !len[0] && (sum2 == 4'd0 || sum2 == 4'd3 || sum2 == 4'd6 || sum2 == 4'd9);
	endfunction

endpackage

// ----- rtl/h2sp_entry_apply.sv -----
// Decode of one complete 6-byte settings entry and update of the peer settings.
`timescale 1ns / 1ps

module h2sp_entry_apply import h2sp_pkg::*; (
	input  logic        apply,
	input  logic [47:0] entry,
	input  status_t     fs_in,
	input  logic [31:0] delta_in,
	input  peer_t       peer_in,
	output status_t     fs_out,
	output logic [31:0] delta_out,
	output peer_t       peer_out
);

	logic [15:0] id;
	logic [31:0] value;

	assign id = entry[47:32];
	assign value = entry[31:0];

	always_comb begin
		fs_out = fs_in;
		delta_out = delta_in;
		peer_out = peer_in;
		if (apply) begin
			case (id)
				IdMaxStreams: begin
					peer_out.max_streams = value;
				end
				IdInitWindow: begin
					if (value > MaxWindow) begin
						fs_out = ST_BAD_WINDOW;
					end else begin
						// wraps mod 2^32; the true delta always fits 32 signed bits
						delta_out = delta_in + (value - {1'b0, peer_in.initial_window});
						peer_out.initial_window = value[30:0];
					end
				end
				IdMaxFrame: begin
					if (value < MinFrame || value > MaxFrame) begin
						fs_out = ST_BAD_FRAME;
					end else begin
						peer_out.max_frame = value[23:0];
					end
				end
				IdMaxHdrList: begin
					peer_out.max_header_list = value;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/http2_settings_payload_parser.sv -----
// Top level of the HTTP/2 SETTINGS payload parser.
`timescale 1ns / 1ps

// Takes one SETTINGS payload byte per beat, each beat carrying the frame's total
// payload length, and accepts a new beat every cycle while input ready is high.
// Beats pass an input register, then entry assembly and settings update load the
// result register. A frame gives one result on its last byte (or at once for a
// zero-length beat) with status, window delta and the stored peer settings. Input
// ready drops only while the result register holds an untaken result and the
// waiting byte would produce another.
module http2_settings_payload_parser import h2sp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         payload_byte,
	input  logic [23:0]        payload_length,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] window_diff,
	output logic [31:0]        max_streams,
	output logic [30:0]        initial_window,
	output logic [23:0]        max_frame,
	output logic [31:0]        max_header_list
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [23:0] len_s1;

	// frame state
	logic [23:0] cnt_q;
	logic [2:0]  ph_q;
	logic [39:0] shift_q;
	status_t     fs_q;
	logic [31:0] delta_q;
	peer_t       peer_q;

	// result register
	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] delta_out_q;
	peer_t       peer_out_q;

	logic        zero_len;
	logic        first;
	status_t     fs_base;
	logic [31:0] delta_base;
	logic [2:0]  ph_base;
	logic [47:0] entry;
	logic        entry_done;
	logic        apply;
	logic [23:0] cnt_next;
	logic        frame_done;
	logic        emit;
	logic        slot_free;
	logic        process;
	status_t     fs_new;
	logic [31:0] delta_new;
	peer_t       peer_new;

	assign zero_len = (len_s1 == '0);
	assign first = (cnt_q == '0);
	assign fs_base = first ? (len_mult6(len_s1) ? ST_OK : ST_BAD_LEN) : fs_q;
	assign delta_base = first ? '0 : delta_q;
	assign ph_base = first ? '0 : ph_q;
	assign entry = first ? {40'd0, byte_s1} : {shift_q, byte_s1};
	assign entry_done = (ph_base == 3'(EntryBytes - 1));
	assign apply = (fs_base == ST_OK) && entry_done;
	// count stays below the largest length, so no wrap
	assign cnt_next = cnt_q + 24'd1;
	assign frame_done = (cnt_next >= len_s1);
	assign emit = zero_len || frame_done;

	assign slot_free = !out_valid_q || out_ready;
	assign process = valid_s1 && (!emit || slot_free);
	assign in_ready = !valid_s1 || process;

	h2sp_entry_apply u_apply (
		.apply     (apply),
		.entry     (entry),
		.fs_in     (fs_base),
		.delta_in  (delta_base),
		.peer_in   (peer_q),
		.fs_out    (fs_new),
		.delta_out (delta_new),
		.peer_out  (peer_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= payload_byte;
			len_s1 <= payload_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ph_q <= '0;
			shift_q <= '0;
			fs_q <= ST_OK;
			delta_q <= '0;
			peer_q <= '{ResetMaxStreams, ResetInitWindow, ResetMaxFrame, ResetMaxHdrList};
		end else if (process) begin
			if (zero_len) begin
				cnt_q <= '0;
				ph_q <= '0;
				shift_q <= '0;
				fs_q <= ST_OK;
				delta_q <= '0;
			end else begin
				cnt_q <= frame_done ? '0 : cnt_next;
				ph_q <= entry_done ? '0 : ph_base + 3'd1;
				shift_q <= entry[39:0];
				fs_q <= fs_new;
				delta_q <= delta_new;
				peer_q <= peer_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && emit) begin
			if (zero_len) begin
				status_q <= ST_OK;
				delta_out_q <= '0;
				peer_out_q <= peer_q;
			end else begin
				status_q <= fs_new;
				delta_out_q <= delta_new;
				peer_out_q <= peer_new;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign window_diff = $signed(delta_out_q);
	assign max_streams = peer_out_q.max_streams;
	assign initial_window = peer_out_q.initial_window;
	assign max_frame = peer_out_q.max_frame;
	assign max_header_list = peer_out_q.max_header_list;

	// entry phase counter never leaves 0..5
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q < 3'(EntryBytes))
		else $error("entry phase out of range");

	// stored max frame size always stays legal
	a_frame_legal: assert property (@(posedge clk) disable iff (!arst_n)
		peer_q.max_frame >= MinFrame[23:0])
		else $error("stored max frame size below minimum");

	// a frame rejected for length applies nothing, so its delta is zero
	a_bad_len_delta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_LEN |-> window_diff == 32'sd0)
		else $error("length-rejected frame reports nonzero delta");

	// a stalled result is not overwritten
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> process == 1'b0 || emit == 1'b0 || out_ready)
		else $error("result register overwritten while stalled");

endmodule
